// ===== sv/slci_pkg.sv =====
// Shared types, constants and text tables for the serial line command interpreter.
// No dependencies; every other file of the block but slci_ram imports this package.
package slci_pkg;

    // Default line size: the line holds at most LINE_SIZE_DEF-1 characters.
    localparam int LINE_SIZE_DEF = 32;

    // Register reset values.
    localparam logic        TTY_ECHO_RST     = 1'b0;
    localparam logic [15:0] MOVE_DELAY_RST   = 16'd1000;
    localparam logic [15:0] MAX_DISTANCE_RST = 16'd10000;

    // Distance accumulator saturates at this value.
    localparam logic [16:0] DIST_CAP = 17'd65536;

    // Character codes.
    localparam logic [7:0] CH_BS    = 8'h08;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_DEL   = 8'h7F;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_UC_A  = 8'h41;
    localparam logic [7:0] CH_UC_Z  = 8'h5A;
    localparam logic [7:0] CASE_OFS = 8'h20;

    // Configuration register indexes.
    typedef enum logic [1:0] {
        CFG_TTY_ECHO     = 2'd0,
        CFG_MOVE_DELAY   = 2'd1,
        CFG_MAX_DISTANCE = 2'd2
    } t_cfg_idx;

    // Input item kinds.
    localparam logic CMD_BYTE = 1'b0;
    localparam logic CMD_TICK = 1'b1;

    // Messages the block can send.
    typedef enum logic [2:0] {
        M_CHAR,    // echo of one printable byte
        M_ERASE,   // backspace, space, backspace
        M_NL,      // echoed newline alone
        M_ERR,     // "ERROR\n"
        M_NL_ERR,  // echoed newline then "ERROR\n"
        M_OK       // "OK\n"
    } t_msg;

    // Result of scanning one line.
    typedef struct packed {
        logic is_move;
        logic move_ok;
    } t_parse_res;

    // Number of bytes in a message.
    function automatic logic [2:0] msg_len(input t_msg msg);
        logic [2:0] len;
        unique case (msg)
            M_CHAR:   len = 3'd1;
            M_ERASE:  len = 3'd3;
            M_NL:     len = 3'd1;
            M_ERR:    len = 3'd6;
            M_NL_ERR: len = 3'd7;
            M_OK:     len = 3'd3;
            default:  len = 3'd1;
        endcase
        return len;
    endfunction

    // Byte idx of the "ERROR\n" text.
    function automatic logic [7:0] err_byte(input logic [2:0] idx);
        logic [7:0] b;
        unique case (idx)
            3'd0:    b = "E";
            3'd1:    b = "R";
            3'd2:    b = "R";
            3'd3:    b = "O";
            3'd4:    b = "R";
            default: b = CH_LF;
        endcase
        return b;
    endfunction

    // Byte idx of a message; ch supplies the echoed byte.
    function automatic logic [7:0] msg_byte(input t_msg msg, input logic [2:0] idx,
                                            input logic [7:0] ch);
        logic [7:0] b;
        unique case (msg)
            M_CHAR:   b = ch;
            M_ERASE:  b = (idx == 3'd1) ? CH_SPACE : CH_BS;
            M_NL:     b = CH_LF;
            M_ERR:    b = err_byte(idx);
            M_NL_ERR: b = (idx == 3'd0) ? CH_LF : err_byte(idx - 3'd1);
            M_OK:     b = (idx == 3'd0) ? 8'("O") : ((idx == 3'd1) ? 8'("K") : CH_LF);
            default:  b = CH_LF;
        endcase
        return b;
    endfunction

    // Letter idx of the command word, in lower case.
    function automatic logic [7:0] word_char(input logic [1:0] idx);
        logic [7:0] b;
        unique case (idx)
            2'd0:    b = "m";
            2'd1:    b = "o";
            2'd2:    b = "v";
            default: b = "e";
        endcase
        return b;
    endfunction

    // Upper-case letters fold to lower case; everything else passes.
    function automatic logic [7:0] to_lower(input logic [7:0] c);
        return (c >= CH_UC_A && c <= CH_UC_Z) ? c + CASE_OFS : c;
    endfunction

    // Decimal digit test.
    function automatic logic is_digit(input logic [7:0] c);
        return (c >= CH_ZERO) && (c <= CH_NINE);
    endfunction

endpackage

// ===== sv/slci_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module slci_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 31,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== sv/slci_parse.sv =====
// Line scanner: walks the stored line one character a cycle through the RAM read port,
// finds the command word and accumulates the distance with one shared multiply-by-ten adder.
// Depends on slci_pkg.
module slci_parse #(
    parameter int LINE_SIZE = slci_pkg::LINE_SIZE_DEF,
    localparam int LW = $clog2(LINE_SIZE),
    localparam int AW = $clog2(LINE_SIZE - 1)
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic [LW-1:0]        i_len,
    input  logic [15:0]          i_max_distance,
    input  logic [7:0]           i_rdata,
    output logic [AW-1:0]        o_raddr,
    output logic                 o_done,
    output slci_pkg::t_parse_res o_res
);

    import slci_pkg::*;

    typedef enum logic {
        P_IDLE,
        P_SCAN
    } t_state;

    // Position within the line.
    typedef enum logic [2:0] {
        PH_LEAD,   // spaces before the first token
        PH_WORD,   // inside the first token
        PH_GAP,    // spaces before the second token
        PH_DIGIT,  // sign or digits of the second token
        PH_STOP    // nothing further matters
    } t_phase;

    t_state     r_state;
    t_phase     r_ph;
    logic [LW-1:0] r_pos;
    logic [2:0] r_wcnt;
    logic       r_mis;
    logic       r_neg;
    logic       r_digits;
    logic [16:0] r_val;
    logic       r_done;
    t_parse_res r_res;

    logic [7:0]  w_lc;
    logic        w_wmatch;
    logic [3:0]  w_digit;
    logic [19:0] w_prod;
    logic [16:0] w_acc;
    logic        w_end;
    logic        w_is_move;

    // Shared unit: value times ten plus the new digit, saturated.
    assign w_digit = 4'(i_rdata - CH_ZERO);
    assign w_prod  = 20'({r_val, 3'b000}) + 20'({r_val, 1'b0}) + 20'(w_digit);
    assign w_acc   = (w_prod > 20'(DIST_CAP)) ? DIST_CAP : w_prod[16:0];

    // Case-blind compare against the command word.
    assign w_lc     = to_lower(i_rdata);
    assign w_wmatch = (r_wcnt < 3'd4) && (w_lc == word_char(r_wcnt[1:0]));

    assign w_end     = (r_pos == i_len) || (r_ph == PH_STOP) || r_mis;
    assign w_is_move = !r_mis && (r_wcnt == 3'd4);

    // Address of the character needed next cycle.
    assign o_raddr = (r_state == P_SCAN) ? AW'(r_pos + LW'(1)) : '0;

    // Sequencer and scan registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= P_IDLE;
            r_ph     <= PH_LEAD;
            r_pos    <= '0;
            r_wcnt   <= '0;
            r_mis    <= 1'b0;
            r_neg    <= 1'b0;
            r_digits <= 1'b0;
            r_val    <= '0;
            r_done   <= 1'b0;
            r_res    <= '0;
        end else begin
            r_done <= 1'b0;
            unique case (r_state)
                P_IDLE: begin
                    if (i_start) begin
                        r_state  <= P_SCAN;
                        r_ph     <= PH_LEAD;
                        r_pos    <= '0;
                        r_wcnt   <= '0;
                        r_mis    <= 1'b0;
                        r_neg    <= 1'b0;
                        r_digits <= 1'b0;
                        r_val    <= '0;
                    end
                end
                P_SCAN: begin
                    if (w_end) begin
                        r_state       <= P_IDLE;
                        r_done        <= 1'b1;
                        r_res.is_move <= w_is_move;
                        r_res.move_ok <= w_is_move && r_digits &&
                                         (r_neg ? (r_val == '0)
                                                : (r_val <= {1'b0, i_max_distance}));
                    end else begin
                        r_pos <= r_pos + LW'(1);
                        unique case (r_ph)
                            PH_LEAD, PH_WORD: begin
                                if (i_rdata == CH_SPACE) begin
                                    if (r_ph == PH_WORD) begin
                                        r_ph <= PH_GAP;
                                    end
                                end else begin
                                    r_ph <= PH_WORD;
                                    if (w_wmatch) begin
                                        r_wcnt <= r_wcnt + 3'd1;
                                    end else begin
                                        r_mis <= 1'b1;
                                    end
                                end
                            end
                            PH_GAP: begin
                                if (i_rdata == CH_PLUS || i_rdata == CH_MINUS) begin
                                    r_neg <= (i_rdata == CH_MINUS);
                                    r_ph  <= PH_DIGIT;
                                end else if (is_digit(i_rdata)) begin
                                    r_val    <= w_acc;
                                    r_digits <= 1'b1;
                                    r_ph     <= PH_DIGIT;
                                end else if (i_rdata != CH_SPACE) begin
                                    r_ph <= PH_STOP;
                                end
                            end
                            PH_DIGIT: begin
                                if (is_digit(i_rdata)) begin
                                    r_val    <= w_acc;
                                    r_digits <= 1'b1;
                                end else begin
                                    r_ph <= PH_STOP;
                                end
                            end
                            default: begin
                                r_ph <= PH_STOP;
                            end
                        endcase
                    end
                end
                default: begin
                    r_state <= P_IDLE;
                end
            endcase
        end
    end

    assign o_done = r_done;
    assign o_res  = r_res;

endmodule

// ===== sv/serial_line_command_interpreter.sv =====
// Serial line command interpreter: line editing with echo and a timed "move" command.
// A tick or an editing byte is taken, then the reply bytes leave one by one as the output takes them.
// A line end scans the stored line at one character a cycle through the line RAM read port,
// then the reply bytes follow. Input is not ready meanwhile.
// Synchronous active-low reset empties the line, clears busy and loads the register defaults.
// Depends on slci_pkg, slci_ram and slci_parse.
module serial_line_command_interpreter #(
    parameter int LINE_SIZE = slci_pkg::LINE_SIZE_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Input transactions
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic        i_command,
    input  logic [7:0]  i_rx_byte,
    // Output transactions
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [7:0]  o_tx_byte,
    output logic        o_last_of_run,
    // Configuration writes
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);

    import slci_pkg::*;

    localparam int LW    = $clog2(LINE_SIZE);
    localparam int AW    = $clog2(LINE_SIZE - 1);
    localparam int DEPTH = LINE_SIZE - 1;

    typedef enum logic [1:0] {
        S_IDLE,
        S_PARSE,
        S_EMIT
    } t_state;

    t_state      r_state;
    logic        r_tty_echo;
    logic [15:0] r_move_delay;
    logic [15:0] r_max_distance;
    logic [LW-1:0] r_len;
    logic        r_busy;
    logic [15:0] r_wait;
    logic        r_start;
    t_msg        r_msg;
    logic [2:0]  r_idx;
    logic [7:0]  r_char;
    logic        r_out_valid;
    logic [7:0]  r_tx_byte;
    logic        r_last;

    logic        w_in_acc;
    logic        w_is_eol;
    logic        w_is_erase;
    logic        w_printable;
    logic        w_room;
    logic        w_we;
    logic [AW-1:0] w_raddr;
    logic [7:0]  w_rdata;
    logic        w_done;
    t_parse_res  w_res;
    logic        w_out_free;
    logic        w_msg_last;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign w_in_acc    = i_in_valid && o_in_ready;

    // Byte classification.
    assign w_is_eol    = (i_rx_byte == CH_CR) || (i_rx_byte == CH_LF);
    assign w_is_erase  = (i_rx_byte == CH_BS) || (i_rx_byte == CH_DEL);
    assign w_printable = (i_rx_byte >= CH_SPACE) && (i_rx_byte < CH_DEL);
    assign w_room      = (r_len != LW'(LINE_SIZE - 1));
    assign w_we        = w_in_acc && (i_command == CMD_BYTE) && !r_busy && !w_is_eol &&
                         !(r_tty_echo && w_is_erase) && w_printable && w_room;

    // Line store.
    slci_ram #(
        .WIDTH (8),
        .DEPTH (DEPTH)
    ) u_line_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (r_len[AW-1:0]),
        .i_wdata (i_rx_byte),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    // Line scanner.
    slci_parse #(
        .LINE_SIZE (LINE_SIZE)
    ) u_parse (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_start        (r_start),
        .i_len          (r_len),
        .i_max_distance (r_max_distance),
        .i_rdata        (w_rdata),
        .o_raddr        (w_raddr),
        .o_done         (w_done),
        .o_res          (w_res)
    );

    // The output register may be reloaded once it is empty or being taken.
    assign w_out_free = !r_out_valid || i_out_ready;
    assign w_msg_last = (r_idx == msg_len(r_msg) - 3'd1);

    // Control sequencer, line state, registers and output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_tty_echo     <= TTY_ECHO_RST;
            r_move_delay   <= MOVE_DELAY_RST;
            r_max_distance <= MAX_DISTANCE_RST;
            r_len          <= '0;
            r_busy         <= 1'b0;
            r_wait         <= '0;
            r_start        <= 1'b0;
            r_msg          <= M_CHAR;
            r_idx          <= '0;
            r_char         <= '0;
            r_out_valid    <= 1'b0;
            r_tx_byte      <= '0;
            r_last         <= 1'b0;
        end else begin
            r_start <= 1'b0;

            // Configuration writes; unknown indexes are ignored.
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    CFG_TTY_ECHO:     r_tty_echo     <= i_cfg_data[0];
                    CFG_MOVE_DELAY:   r_move_delay   <= i_cfg_data;
                    CFG_MAX_DISTANCE: r_max_distance <= i_cfg_data;
                    default: ;
                endcase
            end

            // The consumer takes the waiting byte.
            if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    r_idx <= '0;
                    if (w_in_acc) begin
                        if (i_command == CMD_TICK) begin
                            if (r_busy) begin
                                if (r_wait <= 16'd1) begin
                                    r_wait  <= '0;
                                    r_busy  <= 1'b0;
                                    r_msg   <= M_OK;
                                    r_state <= S_EMIT;
                                end else begin
                                    r_wait <= r_wait - 16'd1;
                                end
                            end
                        end else if (!r_busy) begin
                            priority if (w_is_eol) begin
                                r_start <= 1'b1;
                                r_state <= S_PARSE;
                            end else if (r_tty_echo && w_is_erase) begin
                                if (r_len != '0) begin
                                    r_len   <= r_len - LW'(1);
                                    r_msg   <= M_ERASE;
                                    r_state <= S_EMIT;
                                end
                            end else if (w_printable && w_room) begin
                                r_len  <= r_len + LW'(1);
                                r_char <= i_rx_byte;
                                if (r_tty_echo) begin
                                    r_msg   <= M_CHAR;
                                    r_state <= S_EMIT;
                                end
                            end else begin
                                // Other bytes, and printable bytes once the line is full, are dropped.
                            end
                        end
                    end
                end
                S_PARSE: begin
                    if (w_done) begin
                        r_len <= '0;
                        if (w_res.move_ok) begin
                            r_busy <= 1'b1;
                            r_wait <= r_move_delay;
                        end
                        priority if (!w_res.is_move) begin
                            r_msg   <= r_tty_echo ? M_NL_ERR : M_ERR;
                            r_state <= S_EMIT;
                        end else if (r_tty_echo) begin
                            r_msg   <= M_NL;
                            r_state <= S_EMIT;
                        end else begin
                            r_state <= S_IDLE;
                        end
                    end
                end
                S_EMIT: begin
                    if (w_out_free) begin
                        r_out_valid <= 1'b1;
                        r_tx_byte   <= msg_byte(r_msg, r_idx, r_char);
                        r_last      <= w_msg_last;
                        r_idx       <= r_idx + 3'd1;
                        if (w_msg_last) begin
                            r_state <= S_IDLE;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_tx_byte     = r_tx_byte;
    assign o_last_of_run = r_last;

endmodule

// ===== verif/serial_line_command_interpreter_test.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the serial line command interpreter: line editing, echo,
// the "move" command and its timed OK reply. Needs slci_pkg and the block's RTL only.
module serial_line_command_interpreter_test;
    import slci_pkg::*;

    localparam int LINE_MAX       = LINE_SIZE_DEF - 1;
    localparam int RESET_CYCLES   = 10;
    localparam int SETTLE_CYCLES  = LINE_SIZE_DEF + 8;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int RANDOM_ITEMS   = 20;
    localparam int HOLD_CYCLES    = 400;

    // Index that addresses no register; writes to it must be ignored.
    localparam logic [1:0] CFG_NONE = 2'd3;

    // One expected transmit transaction.
    typedef struct packed {
        logic [7:0] tx_byte;
        logic       last_of_run;
    } t_tx_item;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_ready;
    logic        i_command = CMD_BYTE;
    logic [7:0]  i_rx_byte = 8'h00;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    logic [7:0]  o_tx_byte;
    logic        o_last_of_run;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index = 2'd0;
    logic [15:0] i_cfg_data = 16'd0;

    // Predicted state and register copies.
    logic [7:0]  line_buf [0:LINE_MAX-1];
    int          line_len = 0;
    bit          mv_busy = 1'b0;
    logic [15:0] ticks_left = 16'd0;
    logic        echo_on = TTY_ECHO_RST;
    logic [15:0] delay_reg = MOVE_DELAY_RST;
    logic [15:0] limit_reg = MAX_DISTANCE_RST;

    t_tx_item    tx_expect [$];
    logic [7:0]  reply_bytes [$];
    logic [7:0]  line_bytes [$];

    int          fail_count = 0;
    int          item_count = 0;
    int          idle_max = 8;
    int          stall_max = 8;
    int          hold_left = 0;
    int          quiet_cycles = 0;

    serial_line_command_interpreter u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_command     (i_command),
        .i_rx_byte     (i_rx_byte),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_tx_byte     (o_tx_byte),
        .o_last_of_run (o_last_of_run),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    // Clock generation.
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Adds the text of a reply to the bytes of the current transaction.
    function automatic void add_reply(string s);
        for (int k = 0; k < s.len(); k++) reply_bytes.push_back(s[k]);
    endfunction

    // Scans the finished line and decides between ERROR, a valid move and silence.
    function automatic void eval_line();
        int          i, s1, e1, s2, e2, p;
        bit          is_mv, neg;
        int unsigned val, ndig;
        logic [7:0]  c;
        string       word;
        word = "move";
        neg  = 1'b0;
        val  = 0;
        ndig = 0;
        i    = 0;
        while (i < line_len && line_buf[i] == CH_SPACE) i++;
        s1 = i;
        while (i < line_len && line_buf[i] != CH_SPACE) i++;
        e1 = i;
        while (i < line_len && line_buf[i] == CH_SPACE) i++;
        s2 = i;
        while (i < line_len && line_buf[i] != CH_SPACE) i++;
        e2 = i;

        is_mv = (e1 - s1) == 4;
        for (p = 0; is_mv && p < 4; p++) begin
            c = line_buf[s1 + p];
            if (c >= CH_UC_A && c <= CH_UC_Z) c = c + CASE_OFS;
            if (c != word[p]) is_mv = 1'b0;
        end

        line_len = 0;
        if (!is_mv) begin
            add_reply("ERROR\n");
            return;
        end

        // Optional sign, then decimal digits with saturation.
        p = s2;
        if (p < e2 && (line_buf[p] == CH_PLUS || line_buf[p] == CH_MINUS)) begin
            neg = line_buf[p] == CH_MINUS;
            p++;
        end
        while (p < e2 && line_buf[p] >= CH_ZERO && line_buf[p] <= CH_NINE) begin
            val = val * 10 + 32'(line_buf[p] - CH_ZERO);
            if (val > DIST_CAP) val = DIST_CAP;
            ndig++;
            p++;
        end
        if (ndig > 0 && (neg ? val == 0 : val <= limit_reg)) begin
            mv_busy    = 1'b1;
            ticks_left = delay_reg;
        end
    endfunction

    // Works out the bytes that one accepted transaction sends.
    function automatic void predict_item(logic cmd, logic [7:0] b);
        reply_bytes.delete();
        if (cmd == CMD_TICK) begin
            if (mv_busy) begin
                if (ticks_left <= 16'd1) begin
                    ticks_left = 16'd0;
                    mv_busy    = 1'b0;
                    add_reply("OK\n");
                end else begin
                    ticks_left--;
                end
            end
        end else if (!mv_busy) begin
            if (b == CH_CR || b == CH_LF) begin
                if (echo_on) reply_bytes.push_back(CH_LF);
                eval_line();
            end else if (echo_on && (b == CH_BS || b == CH_DEL)) begin
                if (line_len > 0) begin
                    line_len--;
                    reply_bytes.push_back(CH_BS);
                    reply_bytes.push_back(CH_SPACE);
                    reply_bytes.push_back(CH_BS);
                end
            end else if (b >= CH_SPACE && b < CH_DEL && line_len < LINE_MAX) begin
                line_buf[line_len] = b;
                line_len++;
                if (echo_on) reply_bytes.push_back(b);
            end
        end
        foreach (reply_bytes[k])
            tx_expect.push_back('{reply_bytes[k], k == reply_bytes.size() - 1});
    endfunction

    // Compares one transmitted byte with the oldest expectation.
    function automatic void check_tx(logic [7:0] tx, logic last);
        t_tx_item want;
        if (tx_expect.size() == 0) begin
            $display("%0t: unexpected transaction, expected none, got 0x%02h last %0b",
                     $time, tx, last);
            fail_count++;
            return;
        end
        want = tx_expect.pop_front();
        if (tx !== want.tx_byte) begin
            $display("%0t: tx_byte expected 0x%02h, got 0x%02h", $time, want.tx_byte, tx);
            fail_count++;
        end
        if (last !== want.last_of_run) begin
            $display("%0t: last_of_run expected %0b, got %0b", $time, want.last_of_run, last);
            fail_count++;
        end
    endfunction

    // Output side: checks each transaction, stalls at random and obeys any hold-off.
    initial begin : tx_sink
        int stall;
        stall = 0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_out_valid && i_out_ready) begin
                check_tx(o_tx_byte, o_last_of_run);
                stall = (stall_max > 0) ? $urandom_range(stall_max, 0) : 0;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_out_ready <= 1'b0;
            end else if (stall > 0) begin
                stall--;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= 1'b1;
            end
        end
    end

    // Watchdog: ends the run when no transaction completes for too long.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) ||
                (i_cfg_valid && o_cfg_ready)) begin
                quiet_cycles <= 0;
            end else if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
                $display("%0t: no transaction for %0d cycles", $time, WATCHDOG_LIMIT);
                $display("serial_line_command_interpreter_test NOT OK");
                $finish;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    // Offers one input transaction after a random gap and waits for it to be taken.
    task automatic send_item(input logic cmd, input logic [7:0] b);
        int gap;
        gap = (idle_max > 0) ? $urandom_range(idle_max, 0) : 0;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_command  <= cmd;
        i_rx_byte  <= b;
        do @(posedge i_clk); while (!o_in_ready);
        predict_item(cmd, b);
        item_count++;
    endtask

    task automatic send_text(input string s);
        for (int k = 0; k < s.len(); k++) send_item(CMD_BYTE, s[k]);
    endtask

    // Sends a line followed by a carriage return.
    task automatic send_line(input string s);
        send_text(s);
        send_item(CMD_BYTE, CH_CR);
    endtask

    task automatic flush_line_bytes();
        foreach (line_bytes[k]) send_item(CMD_BYTE, line_bytes[k]);
        line_bytes.delete();
    endtask

    // Ticks until a pending move has been answered.
    task automatic tick_until_idle();
        while (mv_busy) send_item(CMD_TICK, 8'($urandom_range(255, 0)));
    endtask

    // Stops offering input, waits for every expected byte, then lets the block settle.
    task automatic wait_drained();
        i_in_valid <= 1'b0;
        while (tx_expect.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Writes one register while the block is idle.
    task automatic write_reg(input logic [1:0] idx, input logic [15:0] data);
        wait_drained();
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        case (idx)
            CFG_TTY_ECHO:     echo_on   = data[0];
            CFG_MOVE_DELAY:   delay_reg = data;
            CFG_MAX_DISTANCE: limit_reg = data;
            default:          ;
        endcase
    endtask

    // Reset values: echo off and default limit; control bytes dropped.
    task automatic test_plain_editing();
        send_item(CMD_TICK, 8'hA5);
        send_text("ab");
        send_item(CMD_BYTE, CH_BS);
        send_item(CMD_BYTE, 8'h01);
        send_item(CMD_BYTE, 8'h80);
        send_item(CMD_BYTE, 8'hFF);
        send_line("c");
        send_line("");
        send_text("move 10001");
        send_item(CMD_BYTE, CH_LF);
        write_reg(CFG_MOVE_DELAY, 16'd3);
        send_line("  MoVe   10000 x");
        send_text("z");
        tick_until_idle();
    endtask

    // Echo and erase editing, full line, command word matching.
    task automatic test_echo_editing();
        write_reg(CFG_TTY_ECHO, 16'd1);
        send_item(CMD_BYTE, CH_BS);
        send_item(CMD_BYTE, CH_DEL);
        send_text("Ab");
        send_item(CMD_BYTE, CH_DEL);
        send_item(CMD_BYTE, CH_BS);
        send_item(CMD_BYTE, CH_BS);
        send_item(CMD_BYTE, CH_LF);
        send_line("moves 1");
        repeat (LINE_MAX + 1) send_item(CMD_BYTE, "x");
        send_item(CMD_BYTE, CH_CR);
        send_line("move");
        send_line("MOVE -");
    endtask

    // Distance parsing against the limit, including signs, junk and saturation.
    task automatic test_move_distances();
        write_reg(CFG_MOVE_DELAY, 16'd0);
        write_reg(CFG_MAX_DISTANCE, 16'd0);
        send_line("move 0");
        tick_until_idle();
        send_line("move -0");
        tick_until_idle();
        send_line("move -5");
        send_line("move +0");
        tick_until_idle();
        send_line("move abc");
        send_line("move 12ab");
        write_reg(CFG_MAX_DISTANCE, 16'hFFFF);
        send_line("move 65535");
        tick_until_idle();
        send_line("move 65536");
        send_line("move 4294967296");
        write_reg(CFG_NONE, 16'h0000);
        send_line("move +12ab");
        tick_until_idle();
        write_reg(CFG_MOVE_DELAY, 16'd1);
        send_line("move 7");
        tick_until_idle();
        write_reg(CFG_MOVE_DELAY, 16'd2);
        send_line("move 7");
        tick_until_idle();
    endtask

    // A longer delay, ticked back to back.
    task automatic test_long_delay();
        write_reg(CFG_MOVE_DELAY, 16'd12);
        idle_max  = 0;
        stall_max = 0;
        send_line("move 1");
        tick_until_idle();
        idle_max  = 8;
        stall_max = 8;
    endtask

    // The receiver holds off while input keeps coming, then the sender waits for all output.
    task automatic test_output_backpressure();
        write_reg(CFG_TTY_ECHO, 16'd1);
        idle_max  = 0;
        hold_left = HOLD_CYCLES;
        repeat (8) send_item(CMD_BYTE, "q");
        send_item(CMD_BYTE, CH_CR);
        wait_drained();
        idle_max  = 8;
    endtask

    // Random sessions of mostly well-formed lines, with noise and ticks mixed in.
    task automatic test_random_sessions();
        int         start, lines_left, n;
        string      num;
        logic [7:0] c;
        string      word;
        word       = "move";
        start      = item_count;
        lines_left = 0;
        while (item_count < start + RANDOM_ITEMS) begin
            // New phase: registers and idling change while the block is quiet.
            if (lines_left == 0) begin
                write_reg(CFG_TTY_ECHO, 16'($urandom_range(1, 0)));
                write_reg(CFG_MOVE_DELAY, ($urandom_range(5, 0) == 0) ?
                          16'd0 : 16'($urandom_range(4, 1)));
                case ($urandom_range(3, 0))
                    0:       write_reg(CFG_MAX_DISTANCE, 16'd0);
                    1:       write_reg(CFG_MAX_DISTANCE, 16'hFFFF);
                    default: write_reg(CFG_MAX_DISTANCE, 16'($urandom_range(20000, 0)));
                endcase
                idle_max   = $urandom_range(1, 0) ? 8 : 0;
                stall_max  = $urandom_range(1, 0) ? 8 : 0;
                lines_left = $urandom_range(10, 5);
            end
            lines_left--;

            case ($urandom_range(9, 0))
                0, 1, 2, 3, 4: begin
                    // Move command with random case, spacing, sign and value.
                    repeat ($urandom_range(2, 0)) line_bytes.push_back(CH_SPACE);
                    for (int k = 0; k < 4; k++) begin
                        c = word[k];
                        if ($urandom_range(1, 0)) c = c - CASE_OFS;
                        line_bytes.push_back(c);
                    end
                    repeat ($urandom_range(2, 1)) line_bytes.push_back(CH_SPACE);
                    case ($urandom_range(5, 0))
                        0: line_bytes.push_back(CH_PLUS);
                        1: line_bytes.push_back(CH_MINUS);
                        default: ;
                    endcase
                    case ($urandom_range(5, 0))
                        0: num = $sformatf("%0d", $urandom_range(limit_reg, 0));
                        1: num = $sformatf("%0d", 32'(limit_reg) + $urandom_range(2, 0));
                        2: num = $sformatf("%0d", 32'd65535 + $urandom_range(1, 0));
                        3: num = $sformatf("%0d", $urandom);
                        4: num = "0";
                        default: num = "";
                    endcase
                    for (int k = 0; k < num.len(); k++) line_bytes.push_back(num[k]);
                    if ($urandom_range(3, 0) == 0) line_bytes.push_back("k");
                    if ($urandom_range(3, 0) == 0) begin
                        line_bytes.push_back(CH_SPACE);
                        line_bytes.push_back("9");
                    end
                end
                5, 6: begin
                    // Some other first token, possibly none at all.
                    n = $urandom_range(6, 0);
                    repeat (n) line_bytes.push_back(8'($urandom_range(8'h7E, 8'h21)));
                end
                7: begin
                    // Raw noise over the whole byte range.
                    repeat ($urandom_range(6, 1)) line_bytes.push_back(8'($urandom_range(255, 0)));
                end
                8: begin
                    // Typing with erasures in between.
                    repeat ($urandom_range(8, 1)) begin
                        line_bytes.push_back(8'($urandom_range(8'h7E, 8'h20)));
                        if ($urandom_range(3, 0) == 0)
                            line_bytes.push_back($urandom_range(1, 0) ? CH_BS : CH_DEL);
                    end
                end
                default: begin
                    // Overlong line; the excess is dropped.
                    repeat ($urandom_range(40, 32))
                        line_bytes.push_back(8'($urandom_range(8'h7E, 8'h20)));
                end
            endcase
            line_bytes.push_back($urandom_range(1, 0) ? CH_CR : CH_LF);
            flush_line_bytes();

            if ($urandom_range(5, 0) == 0)
                repeat ($urandom_range(3, 1)) send_item(CMD_TICK, 8'($urandom_range(255, 0)));
            if (mv_busy) begin
                // Bytes that arrive while a move is pending are dropped.
                if ($urandom_range(2, 0) == 0)
                    repeat ($urandom_range(2, 1))
                        send_item(CMD_BYTE, 8'($urandom_range(255, 0)));
                tick_until_idle();
            end
        end
    endtask

    // Test sequence.
    initial begin : main_seq
        i_rst_n <= 1'b0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_plain_editing();
        test_echo_editing();
        test_move_distances();
        test_long_delay();
        test_output_backpressure();
        test_random_sessions();

        wait_drained();
        if (fail_count == 0) begin
            $display("serial_line_command_interpreter_test OK");
        end else begin
            $display("serial_line_command_interpreter_test NOT OK");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
sv/slci_pkg.sv
sv/slci_ram.sv
sv/slci_parse.sv
sv/serial_line_command_interpreter.sv
verif/serial_line_command_interpreter_test.sv
